// ----- hdl/mks_pkg.sv -----
// Shared types and constants of the matrix keypad scanner.
// No dependencies; imported by matrix_keypad_scanner_top and its testbench.
`default_nettype none

package mks_pkg;

	// Field widths
	localparam int RowW     = 5;
	localparam int ColW     = 4;
	localparam int KeyW     = 8;
	localparam int TypeW    = 2;
	localparam int DebW     = 8;
	localparam int TableW   = 64;
	localparam int RowIdxW  = 3;
	localparam int ColIdxW  = 2;
	localparam int CfgIdxW  = 2;
	localparam int InDataW  = 8;
	localparam int OutDataW = 16;

	// Parameter defaults
	localparam int SettleTicksDef = 5;
	localparam int MaxRowsDef     = 5;
	localparam int MaxColumnsDef  = 4;

	// Register indexes
	localparam logic [CfgIdxW-1:0] REG_KEYPAD_TYPE    = 2'd0;
	localparam logic [CfgIdxW-1:0] REG_DEBOUNCE_MS    = 2'd1;
	localparam logic [CfgIdxW-1:0] REG_KEY_TABLE_LOW  = 2'd2;
	localparam logic [CfgIdxW-1:0] REG_KEY_TABLE_HIGH = 2'd3;

	// Keypad type codes
	localparam logic [TypeW-1:0] KP_4X4 = 2'd0;
	localparam logic [TypeW-1:0] KP_4X3 = 2'd1;
	localparam logic [TypeW-1:0] KP_5X3 = 2'd2;

	// Reset values and special codes
	localparam logic [DebW-1:0] DEBOUNCE_RESET = 8'd10;
	localparam logic [KeyW-1:0] NO_KEY         = 8'hFF;
	localparam logic [RowIdxW-1:0] ROW_LINES   = 3'd5;

	typedef enum logic [4:0] {
		PH_IDLE     = 5'b00001,
		PH_SETTLE   = 5'b00010,
		PH_TEST     = 5'b00100,
		PH_DEBOUNCE = 5'b01000,
		PH_RELEASE  = 5'b10000
	} phase_t;

endpackage

`default_nettype wire

// ----- hdl/matrix_keypad_scanner_top.sv -----
// Matrix keypad scanner: column sweep, row test, key table decode, debounce and release wait.
// Depends on mks_pkg.
`default_nettype none

// Channel   Dir  Handshake                 Payload
// s_axis    in   s_axis_tvalid/tready      row_levels, ms_pulse, scan_start
// m_axis    out  m_axis_tvalid/tready      column_drive, scan_done, key_code, busy_res
// cfg       in   cfg_we (no wait)          cfg_index, cfg_data
//
// Each request gives exactly one result. The scan state and the result register load
// together at the accepting edge, so one request per clock is taken while results are not held back.
// The result register sits between the sides: a new request is taken while the result
// waits, provided the waiting result is taken in the same cycle.
// arst_n clears the scan state, the result register and the registers to their defaults.

module matrix_keypad_scanner_top
	import mks_pkg::*;
#(
	parameter int SETTLE_TICKS = SettleTicksDef,
	parameter int MAX_ROWS     = MaxRowsDef,
	parameter int MAX_COLUMNS  = MaxColumnsDef
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  s_axis_tvalid,
	output logic                 s_axis_tready,
	// [4:0] row_levels, [5] ms_pulse, [6] scan_start, [7] zero
	input  wire  [InDataW-1:0]   s_axis_tdata,
	output logic                 m_axis_tvalid,
	input  wire                  m_axis_tready,
	// [3:0] column_drive, [4] scan_done, [12:5] key_code, [13] busy_res, [15:14] zero
	output logic [OutDataW-1:0]  m_axis_tdata,
	input  wire                  cfg_we,
	input  wire  [CfgIdxW-1:0]   cfg_index,
	input  wire  [TableW-1:0]    cfg_data
);

	localparam int SettleW = $clog2(SETTLE_TICKS + 1);
	localparam int EntryW  = 5;

	// Configuration
	logic [TypeW-1:0]  keypad_type_q;
	logic [DebW-1:0]   debounce_ms_q;
	logic [TableW-1:0] table_low_q;
	logic [TableW-1:0] table_high_q;

	// Scan state
	phase_t              phase_q, phase_d;
	logic [ColIdxW-1:0]  col_q, col_d;
	logic [RowIdxW-1:0]  row_q, row_d;
	logic [SettleW-1:0]  settle_q, settle_d;
	logic [DebW-1:0]     deb_q, deb_d;
	logic [KeyW-1:0]     found_q, found_d;

	logic                out_valid_q;
	logic [OutDataW-1:0] out_data_q;

	logic [RowW-1:0]     row_levels;
	logic                ms_pulse;
	logic                scan_start;
	logic                accept;

	logic [RowIdxW-1:0]  num_rows;
	logic [RowIdxW-1:0]  num_cols;
	logic                row_low;
	logic [EntryW-1:0]   entry;
	logic [KeyW-1:0]     entry_code;
	logic [2*TableW-1:0] key_table;
	logic [RowIdxW:0]    row_next;
	logic [ColIdxW:0]    col_next;
	logic [DebW-1:0]     deb_inc;
	logic                done;
	logic [ColW-1:0]     column_drive;
	logic [KeyW-1:0]     key_code;

	assign row_levels = s_axis_tdata[RowW-1:0];
	assign ms_pulse   = s_axis_tdata[RowW];
	assign scan_start = s_axis_tdata[RowW+1];

	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	// Keypad size, capped by the parameters; unused type code reads as 4x4
	always_comb begin
		num_rows = (keypad_type_q == KP_5X3) ? 3'd5 : 3'd4;
		if (num_rows > RowIdxW'(MAX_ROWS))
			num_rows = RowIdxW'(MAX_ROWS);
		num_cols = (keypad_type_q == KP_4X3 || keypad_type_q == KP_5X3) ? 3'd3 : 3'd4;
		if (num_cols > RowIdxW'(MAX_COLUMNS))
			num_cols = RowIdxW'(MAX_COLUMNS);
	end

	// Rows above the wired lines read as pulled down
	assign row_low = (row_q < ROW_LINES) ? !row_levels[row_q] : 1'b1;

	// Table entry row * columns + column; entries above 15 decode as no key
	assign key_table  = {table_high_q, table_low_q};
	assign entry      = EntryW'(row_q) * EntryW'(num_cols) + EntryW'(col_q);
	assign entry_code = entry[EntryW-1] ? NO_KEY : key_table[entry[EntryW-2:0] * KeyW +: KeyW];

	assign row_next = {1'b0, row_q} + 1'b1;
	assign col_next = {1'b0, col_q} + 1'b1;
	assign deb_inc  = deb_q + 1'b1;

	always_comb begin
		phase_d  = phase_q;
		col_d    = col_q;
		row_d    = row_q;
		settle_d = settle_q;
		deb_d    = deb_q;
		found_d  = found_q;
		done     = 1'b0;
		case (phase_q)
			PH_IDLE: begin
				if (scan_start) begin
					col_d    = '0;
					row_d    = '0;
					settle_d = '0;
					deb_d    = '0;
					found_d  = NO_KEY;
					phase_d  = PH_SETTLE;
				end
			end
			PH_SETTLE: begin
				settle_d = settle_q + 1'b1;
				if (settle_d >= SettleW'(SETTLE_TICKS)) begin
					row_d   = '0;
					phase_d = PH_TEST;
				end
			end
			PH_TEST: begin
				if (row_q < ROW_LINES && row_low) begin
					found_d = entry_code;
					deb_d   = '0;
					phase_d = PH_DEBOUNCE;
				end
			end
			PH_DEBOUNCE: begin
				if (deb_q >= debounce_ms_q) begin
					phase_d = PH_RELEASE;
				end else if (ms_pulse) begin
					deb_d = deb_inc;
					if (deb_inc >= debounce_ms_q)
						phase_d = PH_RELEASE;
				end
			end
			PH_RELEASE: ;
			default: phase_d = PH_IDLE;
		endcase

		// Advance to the next row, then the next column, then end the sweep
		if ((phase_q == PH_TEST && !(row_q < ROW_LINES && row_low)) ||
		    (phase_q == PH_RELEASE && (row_q >= ROW_LINES || !row_low))) begin
			if (row_next < {1'b0, num_rows}) begin
				row_d   = row_next[RowIdxW-1:0];
				phase_d = PH_TEST;
			end else begin
				row_d = '0;
				if ({1'b0, col_next} < {1'b0, num_cols}) begin
					col_d    = col_next[ColIdxW-1:0];
					settle_d = '0;
					phase_d  = PH_SETTLE;
				end else begin
					col_d   = '0;
					phase_d = PH_IDLE;
					done    = 1'b1;
				end
			end
		end
	end

	assign column_drive = (phase_d == PH_IDLE) ? '1 : ~(ColW'(1) << col_d);
	assign key_code     = done ? found_d : NO_KEY;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keypad_type_q <= KP_4X4;
			debounce_ms_q <= DEBOUNCE_RESET;
			table_low_q   <= '0;
			table_high_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_KEYPAD_TYPE:    keypad_type_q <= cfg_data[TypeW-1:0];
				REG_DEBOUNCE_MS:    debounce_ms_q <= cfg_data[DebW-1:0];
				REG_KEY_TABLE_LOW:  table_low_q   <= cfg_data;
				REG_KEY_TABLE_HIGH: table_high_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			col_q       <= '0;
			row_q       <= '0;
			settle_q    <= '0;
			deb_q       <= '0;
			found_q     <= NO_KEY;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
		end else begin
			if (accept) begin
				phase_q    <= phase_d;
				col_q      <= col_d;
				row_q      <= row_d;
				settle_q   <= settle_d;
				deb_q      <= deb_d;
				found_q    <= found_d;
				out_data_q <= {2'b00, (phase_d != PH_IDLE), key_code, done, column_drive};
			end
			// Hold the result until taken; refill on a new request
			if (accept)
				out_valid_q <= 1'b1;
			else if (m_axis_tready)
				out_valid_q <= 1'b0;
		end
	end

endmodule

`default_nettype wire

// ----- verif/tb_matrix_keypad_scanner_top.sv -----
// Self-checking testbench for matrix_keypad_scanner_top: directed ticks, then random key traffic.
// Keeps its own scan predictor and checks every result; depends on mks_pkg and the top level.
`timescale 1ns / 100ps

module tb_matrix_keypad_scanner_top;
	import mks_pkg::*;

	localparam int ITEM_TARGET = 1950;
	localparam int STALL_LIMIT = 2000;
	localparam int PRINT_LIMIT = 40;

	typedef struct packed {
		logic [1:0]      pad;
		logic            busy;
		logic [KeyW-1:0] key;
		logic            done;
		logic [ColW-1:0] cols;
	} scan_result_t;

	typedef enum bit {STEP_TICK, STEP_CFG} step_kind_t;

	typedef struct {
		step_kind_t          kind;
		logic [CfgIdxW-1:0]  idx;
		logic [TableW-1:0]   val;
		logic [RowW-1:0]     rows;
		logic                ms;
		logic                start;
		bit                  typed;
		scan_result_t        want;
	} plan_row_t;

	typedef enum {RX_FREE, RX_RANDOM, RX_SPARSE, RX_PERIODIC, RX_HOLD} rx_mode_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_valid = 1'b0;
	logic [InDataW-1:0] s_data = '0;
	logic m_ready = 1'b0;
	logic cfg_we = 1'b0;
	logic [CfgIdxW-1:0] cfg_index = '0;
	logic [TableW-1:0] cfg_data = '0;
	wire s_axis_tready;
	wire m_axis_tvalid;
	wire [OutDataW-1:0] m_axis_tdata;

	// Predictor copy of the registers and the scan state
	logic [TypeW-1:0]   kp_type = KP_4X4;
	logic [DebW-1:0]    deb_ms = DEBOUNCE_RESET;
	logic [TableW-1:0]  tbl_low = '0;
	logic [TableW-1:0]  tbl_high = '0;
	phase_t             scan_phase = PH_IDLE;
	logic [ColIdxW-1:0] col_idx = '0;
	logic [RowIdxW-1:0] row_idx = '0;
	logic [2:0]         settle_cnt = '0;
	logic [DebW-1:0]    deb_cnt = '0;
	logic [KeyW-1:0]    last_key = NO_KEY;

	scan_result_t pending_scans[$];
	plan_row_t    dir_plan[$];

	int unsigned errors = 0;
	int unsigned items_sent = 0;
	int unsigned results_seen = 0;
	int unsigned sweeps_done = 0;
	int unsigned keys_seen = 0;
	int unsigned cfg_writes = 0;
	int unsigned burst_left = 0;
	int unsigned idle_cycles = 0;
	bit          key_down = 1'b0;
	int unsigned held_row = 0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	matrix_keypad_scanner_top u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_valid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_data),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_ready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	function automatic int unsigned rows_of_type();
		int unsigned r;
		r = (kp_type == KP_5X3) ? 5 : 4;
		return (r > MaxRowsDef) ? MaxRowsDef : r;
	endfunction

	function automatic int unsigned cols_of_type();
		int unsigned c;
		c = (kp_type == KP_4X3 || kp_type == KP_5X3) ? 3 : 4;
		return (c > MaxColumnsDef) ? MaxColumnsDef : c;
	endfunction

	function automatic logic [KeyW-1:0] key_entry(input int unsigned n);
		if (n < 8)
			return tbl_low[8*n +: 8];
		if (n < 16)
			return tbl_high[8*(n-8) +: 8];
		return NO_KEY;
	endfunction

	// Step to the next row or column; returns 1 when the sweep is over.
	function automatic bit next_row();
		int unsigned nr;
		int unsigned nc;
		nr = row_idx + 1;
		if (nr < rows_of_type()) begin
			row_idx = nr[RowIdxW-1:0];
			scan_phase = PH_TEST;
			return 1'b0;
		end
		row_idx = '0;
		nc = col_idx + 1;
		if (nc < cols_of_type()) begin
			col_idx = nc[ColIdxW-1:0];
			settle_cnt = '0;
			scan_phase = PH_SETTLE;
			return 1'b0;
		end
		col_idx = '0;
		scan_phase = PH_IDLE;
		return 1'b1;
	endfunction

	function automatic scan_result_t scan_tick(input logic [RowW-1:0] rows, input logic ms,
			input logic start);
		scan_result_t r;
		bit done;
		bit row_low;
		done = 1'b0;
		row_low = (row_idx < ROW_LINES) ? !rows[row_idx] : 1'b1;
		case (scan_phase)
			PH_IDLE: if (start) begin
				col_idx = '0;
				row_idx = '0;
				settle_cnt = '0;
				deb_cnt = '0;
				last_key = NO_KEY;
				scan_phase = PH_SETTLE;
			end
			PH_SETTLE: begin
				settle_cnt = settle_cnt + 3'd1;
				if (settle_cnt >= SettleTicksDef) begin
					row_idx = '0;
					scan_phase = PH_TEST;
				end
			end
			PH_TEST: if (row_idx < ROW_LINES && row_low) begin
				last_key = key_entry(row_idx * cols_of_type() + col_idx);
				deb_cnt = '0;
				scan_phase = PH_DEBOUNCE;
			end else begin
				done = next_row();
			end
			PH_DEBOUNCE: if (deb_cnt >= deb_ms) begin
				scan_phase = PH_RELEASE;
			end else if (ms) begin
				deb_cnt = deb_cnt + 8'd1;
				if (deb_cnt >= deb_ms)
					scan_phase = PH_RELEASE;
			end
			PH_RELEASE: if (row_idx >= ROW_LINES || !row_low) begin
				done = next_row();
			end
			default: scan_phase = PH_IDLE;
		endcase
		r.pad = '0;
		r.busy = (scan_phase != PH_IDLE);
		r.cols = r.busy ? ~(4'b0001 << col_idx) : 4'hF;
		r.done = done;
		r.key = done ? last_key : NO_KEY;
		return r;
	endfunction

	function automatic scan_result_t mk_res(input logic [ColW-1:0] cols, input logic done,
			input logic [KeyW-1:0] key, input logic busy);
		scan_result_t r;
		r.pad = '0;
		r.cols = cols;
		r.done = done;
		r.key = key;
		r.busy = busy;
		return r;
	endfunction

	function automatic void add_tick(input logic [RowW-1:0] rows, input logic ms,
			input logic start, input bit typed, input scan_result_t want);
		plan_row_t p;
		p.kind = STEP_TICK;
		p.idx = '0;
		p.val = '0;
		p.rows = rows;
		p.ms = ms;
		p.start = start;
		p.typed = typed;
		p.want = want;
		dir_plan.push_back(p);
	endfunction

	function automatic void add_cfg(input logic [CfgIdxW-1:0] idx, input logic [TableW-1:0] val);
		plan_row_t p;
		p.kind = STEP_CFG;
		p.idx = idx;
		p.val = val;
		p.rows = '1;
		p.ms = 1'b0;
		p.start = 1'b0;
		p.typed = 1'b0;
		p.want = '0;
		dir_plan.push_back(p);
	endfunction

	task automatic report_mismatch(input string what, input logic [15:0] got,
			input logic [15:0] want);
		errors++;
		if (errors <= PRINT_LIMIT)
			$display("%0t ERROR %s: got %h, want %h", $time, what, got, want);
	endtask

	// Offer one tick; the sender pauses between bursts of random length.
	task automatic send_tick(input logic [RowW-1:0] rows, input logic ms, input logic start,
			input bit typed, input scan_result_t want);
		scan_result_t pred;
		if (burst_left == 0) begin
			s_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300)
				: $urandom_range(1, 30);
		end
		burst_left--;
		s_valid <= 1'b1;
		s_data <= {1'b0, start, ms, rows};
		do @(posedge clk); while (!s_axis_tready);
		pred = scan_tick(rows, ms, start);
		pending_scans.push_back(typed ? want : pred);
		items_sent++;
	endtask

	// Drop valid and wait until every pending result has come out.
	task automatic drain();
		s_valid <= 1'b0;
		burst_left = 0;
		while (pending_scans.size() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [TableW-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_KEYPAD_TYPE:    kp_type = val[TypeW-1:0];
			REG_DEBOUNCE_MS:    deb_ms = val[DebW-1:0];
			REG_KEY_TABLE_LOW:  tbl_low = val;
			REG_KEY_TABLE_HIGH: tbl_high = val;
			default: ;
		endcase
		cfg_writes++;
		@(posedge clk);
	endtask

	function automatic logic [TableW-1:0] pick_table();
		case ($urandom_range(0, 5))
			0: return '1;
			1: return '0;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// Rewrite some registers; the scan may be mid-sweep, which is allowed.
	task automatic shuffle_regs(input bit all_regs);
		logic [TableW-1:0] v;
		if (all_regs || $urandom_range(0, 1)) begin
			v = {$urandom, $urandom};
			write_reg(REG_KEYPAD_TYPE, v);
		end
		if (all_regs || $urandom_range(0, 2) == 0) begin
			v = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom} : '0;
			case ($urandom_range(0, 9))
				0: v[7:0] = 8'hFF;
				1: v[7:0] = 8'($urandom_range(0, 255));
				default: v[7:0] = 8'($urandom_range(0, 4));
			endcase
			write_reg(REG_DEBOUNCE_MS, v);
		end
		if (all_regs || $urandom_range(0, 2) == 0)
			write_reg(REG_KEY_TABLE_LOW, pick_table());
		if (all_regs || $urandom_range(0, 2) == 0)
			write_reg(REG_KEY_TABLE_HIGH, pick_table());
	endtask

	always @(posedge clk) begin : chk_results
		scan_result_t got;
		scan_result_t want;
		if (arst_n && m_axis_tvalid && m_ready) begin
			got = scan_result_t'(m_axis_tdata);
			results_seen++;
			if (pending_scans.size() == 0) begin
				report_mismatch("result with nothing pending", got, '0);
			end else begin
				want = pending_scans.pop_front();
				if (got.cols !== want.cols)
					report_mismatch("column_drive", got.cols, want.cols);
				if (got.done !== want.done)
					report_mismatch("scan_done", got.done, want.done);
				if (got.key !== want.key)
					report_mismatch("key_code", got.key, want.key);
				if (got.busy !== want.busy)
					report_mismatch("busy_res", got.busy, want.busy);
				if (got.pad !== 2'b00)
					report_mismatch("tdata pad bits", got.pad, 2'b00);
				if (want.done) begin
					sweeps_done++;
					if (want.key != NO_KEY)
						keys_seen++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_valid && s_axis_tready) || (m_axis_tvalid && m_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles == STALL_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Receiver pattern; every seventh segment is a long hold-off that backs up the input.
	initial begin : rx_pattern
		rx_mode_t mode;
		int unsigned seg_len;
		int unsigned seg_no;
		seg_no = 0;
		@(posedge arst_n);
		forever begin
			seg_no++;
			if (seg_no % 7 == 3) begin
				mode = RX_HOLD;
				seg_len = 400;
			end else begin
				mode = rx_mode_t'($urandom_range(0, 3));
				seg_len = $urandom_range(10, 150);
			end
			for (int k = 0; k < seg_len; k++) begin
				@(posedge clk);
				case (mode)
					RX_FREE:     m_ready <= 1'b1;
					RX_RANDOM:   m_ready <= 1'($urandom_range(0, 1));
					RX_SPARSE:   m_ready <= ($urandom_range(0, 3) == 0);
					RX_PERIODIC: m_ready <= (k % 3 == 0);
					default:     m_ready <= 1'b0;
				endcase
			end
		end
	end

	initial begin
		logic [RowW-1:0] rows;
		logic ms;
		logic start;
		int unsigned span;
		int unsigned ms_rate;
		bit first;

		// 5x3 pad, no debounce, entry n decodes as 0x10 + n
		add_cfg(REG_KEYPAD_TYPE, KP_5X3);
		add_cfg(REG_DEBOUNCE_MS, '0);
		add_cfg(REG_KEY_TABLE_LOW, 64'h1716_1514_1312_1110);
		add_cfg(REG_KEY_TABLE_HIGH, 64'h1F1E_1D1C_1B1A_1918);
		add_tick(5'h1F, 1'b0, 1'b0, 1'b1, mk_res(4'hF, 1'b0, NO_KEY, 1'b0));
		add_tick(5'h00, 1'b1, 1'b0, 1'b1, mk_res(4'hF, 1'b0, NO_KEY, 1'b0));
		add_tick(5'h1F, 1'b0, 1'b1, 1'b1, mk_res(4'hE, 1'b0, NO_KEY, 1'b1));
		// settle, with a start request that must be ignored
		for (int i = 0; i < SettleTicksDef; i++)
			add_tick(5'h1F, i[0], (i == 2), 1'b1, mk_res(4'hE, 1'b0, NO_KEY, 1'b1));
		for (int i = 0; i < 4; i++)
			add_tick(5'h1F, 1'b0, 1'b0, 1'b1, mk_res(4'hE, 1'b0, NO_KEY, 1'b1));
		// switch to 4x4 while row 4 is next: its entry lies past the table
		add_cfg(REG_KEYPAD_TYPE, KP_4X4);
		add_tick(5'h0F, 1'b0, 1'b0, 1'b0, '0);
		add_tick(5'h0F, 1'b0, 1'b0, 1'b0, '0);
		add_tick(5'h0F, 1'b0, 1'b0, 1'b0, '0);
		add_tick(5'h1F, 1'b0, 1'b0, 1'b0, '0);
		for (int i = 0; i < SettleTicksDef; i++)
			add_tick(5'h1F, 1'b1, 1'b0, 1'b0, '0);
		add_tick(5'h1E, 1'b0, 1'b0, 1'b0, '0);
		add_tick(5'h1E, 1'b0, 1'b0, 1'b0, '0);
		add_tick(5'h1F, 1'b0, 1'b0, 1'b0, '0);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_plan[i]) begin
			if (dir_plan[i].kind == STEP_CFG) begin
				drain();
				write_reg(dir_plan[i].idx, dir_plan[i].val);
			end else begin
				send_tick(dir_plan[i].rows, dir_plan[i].ms, dir_plan[i].start,
					dir_plan[i].typed, dir_plan[i].want);
			end
		end

		first = 1'b1;
		while (items_sent < ITEM_TARGET) begin
			drain();
			shuffle_regs(first);
			first = 1'b0;
			ms_rate = $urandom_range(5, 100);
			span = $urandom_range(40, 200);
			repeat (span) begin
				// a key goes down or up now and then; hold it long enough to be seen
				if ($urandom_range(0, 19) == 0) begin
					key_down = 1'($urandom_range(0, 1));
					held_row = $urandom_range(0, 4);
				end
				if ($urandom_range(0, 24) == 0)
					rows = RowW'($urandom_range(0, 31));
				else
					rows = key_down ? ~(5'b00001 << held_row) : 5'h1F;
				ms = ($urandom_range(1, 100) <= ms_rate);
				if (scan_phase == PH_IDLE)
					start = ($urandom_range(0, 3) != 0);
				else
					start = ($urandom_range(0, 15) == 0);
				send_tick(rows, ms, start, 1'b0, '0);
			end
		end

		drain();
		repeat (10) @(posedge clk);
		$display("Sent %0d keypad ticks with %0d register writes; checked %0d results.",
			items_sent, cfg_writes, results_seen);
		$display("Saw %0d finished sweeps, %0d of them reporting a key.", sweeps_done, keys_seen);
		if (errors == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
hdl/mks_pkg.sv
hdl/matrix_keypad_scanner_top.sv
verif/tb_matrix_keypad_scanner_top.sv
